// ----- hw/rtl/mth_pkg.sv -----
// ----------------------------------------------------------------------------
// mth_pkg
// Shared field widths, operation and status codes, and the result record of
// the mode tracking histogram.
// ----------------------------------------------------------------------------
package mth_pkg;

    // fixed field widths of the stream items
    localparam int OP_W        = 2;
    localparam int VALUE_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 10;

    // packed stream widths, padded to whole bytes
    localparam int S_FIELDS_W  = OP_W + VALUE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = STATUS_W + VALUE_W + COUNT_OUT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // default sizing
    localparam int DEF_VALUE_COUNT = 1024;
    localparam int DEF_BLOCK_SIZE  = 32;
    localparam int DEF_COUNT_MAX   = 1023;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] mode_count;
        logic [VALUE_W-1:0]     mode_value;
        logic [STATUS_W-1:0]    status;
    } result_t;

endpackage

// ----- hw/rtl/mode_tracking_histogram.sv -----
// ----------------------------------------------------------------------------
// mode_tracking_histogram
// Multiset of small values with add, remove and mode query, kept as a count
// per value plus a per-block histogram of counts and a per-block maximum.
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer when          carries
//  s_axis    in         s_tvalid && s_tready   operation, value
//  m_axis    out        m_tvalid && m_tready   status, mode_value, mode_count
//
//  add / remove: accept, count read, then two histogram read-modify-write
//    steps; add at the count limit or remove of an absent value: accept and
//    count read only; out-of-range value or unused operation: accept only
//  query: a walk over every block maximum, then over the winning block up to
//    its first value at the maximum (no walk for an empty set), paced by the
//    one-per-cycle read port of each memory
//  after reset a clearing pass over max(VALUE_COUNT, NUM_BLOCKS * 2**clog2(COUNT_MAX+1))
//    addresses (32768 at the defaults) zeroes the memories; s_tready stays low
//  a result register sits on the output, so the next item is taken while a
//    result waits; a second finished result holds in the engine until it frees
//
module mode_tracking_histogram #(
    parameter int VALUE_COUNT = mth_pkg::DEF_VALUE_COUNT,
    parameter int BLOCK_SIZE  = mth_pkg::DEF_BLOCK_SIZE,
    parameter int COUNT_MAX   = mth_pkg::DEF_COUNT_MAX
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mth_pkg::S_TDATA_W-1:0]   s_tdata,   // operation[1:0], value[11:2], zero
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mth_pkg::M_TDATA_W-1:0]   m_tdata    // status[1:0], mode_value[11:2],
                                                       // mode_count[21:12], zero
);

    import mth_pkg::*;

    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic               res_valid;
    logic               res_ready;
    result_t            res;
    result_t            m_res;

    // unpack the input transfer, lowest field first
    assign op    = s_tdata[OP_W-1:0];
    assign value = s_tdata[OP_W +: VALUE_W];

    // memory sequencer: clearing pass, update read-modify-writes, query walk
    mth_engine #(
        .VALUE_COUNT (VALUE_COUNT),
        .BLOCK_SIZE  (BLOCK_SIZE),
        .COUNT_MAX   (COUNT_MAX)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (op),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register decouples the engine from downstream stalls
    mth_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    // pack status lowest, then mode value, then mode count, zero padded
    assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, m_res};

endmodule

// ----- hw/rtl/mth_ram.sv -----
// ----------------------------------------------------------------------------
// mth_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mth_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/mth_out_reg.sv -----
// ----------------------------------------------------------------------------
// mth_out_reg
// One-entry result register between the engine and the master stream.
// ----------------------------------------------------------------------------
module mth_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    output logic             res_ready,
    input  mth_pkg::result_t res,
    output logic             m_valid,
    input  logic             m_ready,
    output mth_pkg::result_t m_res
);

    import mth_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

endmodule

// ----- hw/rtl/mth_engine.sv -----
// ----------------------------------------------------------------------------
// mth_engine
// Sequencer around the count, histogram and block maximum memories: clears
// them after reset, runs add/remove read-modify-writes and the mode query.
// ----------------------------------------------------------------------------
module mth_engine #(
    parameter int VALUE_COUNT = mth_pkg::DEF_VALUE_COUNT,
    parameter int BLOCK_SIZE  = mth_pkg::DEF_BLOCK_SIZE,
    parameter int COUNT_MAX   = mth_pkg::DEF_COUNT_MAX
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mth_pkg::OP_W-1:0]     op,
    input  logic [mth_pkg::VALUE_W-1:0]  value,
    output logic                         res_valid,
    input  logic                         res_ready,
    output mth_pkg::result_t             res
);

    import mth_pkg::*;

    localparam int NUM_BLOCKS = (VALUE_COUNT + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int CW         = $clog2(COUNT_MAX + 1);
    localparam int HW         = $clog2(BLOCK_SIZE + 1);
    localparam int VAW        = $clog2(VALUE_COUNT);
    localparam int BAW        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int HIST_DEPTH = NUM_BLOCKS * (2 ** CW);
    localparam int HAW        = $clog2(HIST_DEPTH);
    localparam int CLR_LEN    = (VALUE_COUNT > HIST_DEPTH) ? VALUE_COUNT : HIST_DEPTH;
    localparam int CLRW       = $clog2(CLR_LEN);
    localparam int QW         = $clog2(NUM_BLOCKS + 1);
    localparam int SBW        = $clog2(NUM_BLOCKS * BLOCK_SIZE + 1);
    // block index by reciprocal multiply, exact for every VALUE_W-bit value
    localparam int DIV_SH     = VALUE_W + $clog2(BLOCK_SIZE);
    localparam int DIV_MUL    = ((2 ** DIV_SH) + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int DMW        = VALUE_W + 1;
    localparam int PW         = VALUE_W + DMW;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_H1,
        S_H2,
        S_QMAX,
        S_QSTART,
        S_QBLK,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CLRW-1:0] clr_idx_reg, clr_idx_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [VAW-1:0]  vaddr_reg, vaddr_next;
    logic [BAW-1:0]  blk_reg, blk_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [QW-1:0]   qidx_reg, qidx_next;
    logic [SBW-1:0]  scan_base_reg, scan_base_next;
    logic [CW-1:0]   best_reg, best_next;
    logic [SBW-1:0]  best_base_reg, best_base_next;
    logic [SBW-1:0]  lim_reg, lim_next;
    logic [SBW-1:0]  qv_reg, qv_next;
    result_t         res_reg, res_next;

    // memory ports
    logic           vc_we;
    logic [VAW-1:0] vc_waddr, vc_raddr;
    logic [CW-1:0]  vc_wdata, vc_rdata;
    logic           hs_we;
    logic [HAW-1:0] hs_waddr, hs_raddr;
    logic [HW-1:0]  hs_wdata, hs_rdata;
    logic           bm_we;
    logic [BAW-1:0] bm_waddr, bm_raddr;
    logic [CW-1:0]  bm_wdata, bm_rdata;

    logic           start;
    logic           in_range;
    logic [PW-1:0]  div_prod;
    logic [BAW-1:0] blk_in;
    logic [CW-1:0]  cnt_new;
    logic [SBW-1:0] lim_sum;
    logic [SBW-1:0] qv_inc;

    mth_ram #(.WIDTH(CW), .DEPTH(VALUE_COUNT)) u_counts (
        .clk   (clk),
        .we    (vc_we),
        .waddr (vc_waddr),
        .wdata (vc_wdata),
        .raddr (vc_raddr),
        .rdata (vc_rdata)
    );

    mth_ram #(.WIDTH(HW), .DEPTH(HIST_DEPTH)) u_hist (
        .clk   (clk),
        .we    (hs_we),
        .waddr (hs_waddr),
        .wdata (hs_wdata),
        .raddr (hs_raddr),
        .rdata (hs_rdata)
    );

    mth_ram #(.WIDTH(CW), .DEPTH(NUM_BLOCKS)) u_blkmax (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_DONE) && res_ready);
    assign start     = in_valid && in_ready;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign in_range  = (32'(value) < VALUE_COUNT);
    assign div_prod  = PW'(value) * PW'(DIV_MUL);
    assign blk_in    = BAW'(div_prod >> DIV_SH);
    assign lim_sum   = best_base_reg + SBW'(BLOCK_SIZE);
    assign qv_inc    = qv_reg + SBW'(1);
    assign cnt_new   = (op_reg == OP_ADD) ? (cnt_reg + CW'(1)) : (cnt_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        op_next        = op_reg;
        vaddr_next     = vaddr_reg;
        blk_next       = blk_reg;
        cnt_next       = cnt_reg;
        qidx_next      = qidx_reg;
        scan_base_next = scan_base_reg;
        best_next      = best_reg;
        best_base_next = best_base_reg;
        lim_next       = lim_reg;
        qv_next        = qv_reg;
        res_next       = res_reg;

        vc_we    = 1'b0;
        vc_waddr = vaddr_reg;
        vc_wdata = cnt_new;
        vc_raddr = VAW'(value);
        hs_we    = 1'b0;
        hs_waddr = HAW'({blk_reg, cnt_reg});
        hs_wdata = hs_rdata - HW'(1);
        hs_raddr = HAW'({blk_reg, cnt_new});
        bm_we    = 1'b0;
        bm_waddr = blk_reg;
        bm_wdata = cnt_new;
        bm_raddr = blk_reg;

        case (state_reg)
            S_CLEAR:
            begin
                vc_we    = (32'(clr_idx_reg) < VALUE_COUNT);
                vc_waddr = VAW'(clr_idx_reg);
                vc_wdata = '0;
                hs_we    = (32'(clr_idx_reg) < HIST_DEPTH);
                hs_waddr = HAW'(clr_idx_reg);
                hs_wdata = '0;
                bm_we    = (32'(clr_idx_reg) < NUM_BLOCKS);
                bm_waddr = BAW'(clr_idx_reg);
                bm_wdata = '0;
                if (clr_idx_reg == CLRW'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + CLRW'(1);
                end
            end
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_RD:
            begin
                // count arrives, fetch its histogram entry
                cnt_next = vc_rdata;
                hs_raddr = HAW'({blk_reg, vc_rdata});
                if (op_reg == OP_ADD)
                begin
                    if (32'(vc_rdata) >= COUNT_MAX)
                    begin
                        res_next   = '{mode_count: '0, mode_value: '0,
                                       status: STATUS_SATURATED};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_H1;
                    end
                end
                else if (vc_rdata == '0)
                begin
                    res_next   = '{mode_count: '0, mode_value: '0, status: STATUS_ABSENT};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_H1;
                end
            end
            S_H1:
            begin
                // leave the old count bucket, fetch the new one
                hs_we = (cnt_reg != '0);
                vc_we = 1'b1;
                if (op_reg == OP_ADD)
                begin
                    bm_we = (cnt_new > bm_rdata);
                end
                else
                begin
                    bm_we = (bm_rdata == cnt_reg) && (hs_rdata == HW'(1));
                end
                cnt_next   = cnt_new;
                state_next = S_H2;
            end
            S_H2:
            begin
                // enter the new count bucket
                hs_we      = (cnt_reg != '0);
                hs_wdata   = hs_rdata + HW'(1);
                res_next   = '{mode_count: '0, mode_value: '0, status: STATUS_OK};
                state_next = S_DONE;
            end
            S_QMAX:
            begin
                // block maxima stream out one per cycle, first strict max wins
                if (bm_rdata > best_reg)
                begin
                    best_next      = bm_rdata;
                    best_base_next = scan_base_reg;
                end
                scan_base_next = scan_base_reg + SBW'(BLOCK_SIZE);
                if (32'(qidx_reg) < NUM_BLOCKS)
                begin
                    bm_raddr  = BAW'(qidx_reg);
                    qidx_next = qidx_reg + QW'(1);
                end
                else
                begin
                    state_next = S_QSTART;
                end
            end
            S_QSTART:
            begin
                if (best_reg == '0)
                begin
                    res_next   = '{mode_count: '0, mode_value: '0, status: STATUS_OK};
                    state_next = S_DONE;
                end
                else
                begin
                    vc_raddr = VAW'(best_base_reg);
                    qv_next  = best_base_reg;
                    lim_next = (32'(lim_sum) > VALUE_COUNT) ? SBW'(VALUE_COUNT) : lim_sum;
                    state_next = S_QBLK;
                end
            end
            S_QBLK:
            begin
                // walk the winning block for the first value at the maximum
                if (vc_rdata == best_reg)
                begin
                    res_next   = '{mode_count: COUNT_OUT_W'(best_reg),
                                   mode_value: VALUE_W'(qv_reg), status: STATUS_OK};
                    state_next = S_DONE;
                end
                else if (qv_inc < lim_reg)
                begin
                    vc_raddr = VAW'(qv_inc);
                    qv_next  = qv_inc;
                end
                else
                begin
                    res_next   = '{mode_count: '0, mode_value: '0, status: STATUS_OK};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new transfer can start from idle or while the result leaves
        if (start)
        begin
            op_next    = op;
            vaddr_next = VAW'(value);
            blk_next   = blk_in;
            case (op)
                OP_ADD, OP_REMOVE:
                begin
                    if (in_range)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        res_next   = '{mode_count: '0, mode_value: '0,
                                       status: (op == OP_ADD) ? STATUS_SATURATED
                                                              : STATUS_ABSENT};
                        state_next = S_DONE;
                    end
                end
                OP_QUERY:
                begin
                    bm_raddr       = '0;
                    qidx_next      = QW'(1);
                    scan_base_next = '0;
                    best_next      = '0;
                    best_base_next = '0;
                    state_next     = S_QMAX;
                end
                default:
                begin
                    res_next   = '{mode_count: '0, mode_value: '0, status: STATUS_OK};
                    state_next = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            op_reg        <= '0;
            vaddr_reg     <= '0;
            blk_reg       <= '0;
            cnt_reg       <= '0;
            qidx_reg      <= '0;
            scan_base_reg <= '0;
            best_reg      <= '0;
            best_base_reg <= '0;
            lim_reg       <= '0;
            qv_reg        <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            op_reg        <= op_next;
            vaddr_reg     <= vaddr_next;
            blk_reg       <= blk_next;
            cnt_reg       <= cnt_next;
            qidx_reg      <= qidx_next;
            scan_base_reg <= scan_base_next;
            best_reg      <= best_next;
            best_base_reg <= best_base_next;
            lim_reg       <= lim_next;
            qv_reg        <= qv_next;
            res_reg       <= res_next;
        end
    end

endmodule

// ----- hw/rtl/mth_checker.sv -----
// ----------------------------------------------------------------------------
// mth_checker
// Port-level checks of the mode tracking histogram, bound to the top level.
// ----------------------------------------------------------------------------
module mth_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mth_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mth_pkg::M_TDATA_W-1:0] m_tdata
);

    import mth_pkg::*;

    logic       s_fire;
    logic       m_fire;
    logic [2:0] pending_reg, pending_next;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // items taken whose result has not left yet
    always_comb
    begin
        pending_next = pending_reg;
        if (s_fire && !m_fire)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (m_fire && !s_fire)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // nothing moves while reset is held low
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid && !s_tready)
        else $error("stream active during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // every result belongs to an earlier input transfer
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 3'd0)
        else $error("result without an input item");

    // the engine plus the result register hold at most two items
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && !m_fire |-> pending_reg < 3'd2)
        else $error("more than two items in flight");

    // a flagged update carries no mode and status stays within its codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] == STATUS_OK) ||
                     (((m_tdata[STATUS_W-1:0] == STATUS_ABSENT) ||
                       (m_tdata[STATUS_W-1:0] == STATUS_SATURATED)) &&
                      (m_tdata[M_TDATA_W-1:STATUS_W] == '0)))
        else $error("bad status or nonzero mode on flagged result");

endmodule

bind mode_tracking_histogram mth_checker u_checker (.*);

// ----- dv/mode_tracker_checker.sv -----
// ----------------------------------------------------------------------------
// mode_tracker_checker
// Watches both stream channels of the mode tracking histogram, keeps its own
// per-value counts, per-block count histograms and block maxima, and checks
// every result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module mode_tracker_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [mth_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mth_pkg::M_TDATA_W-1:0]    m_tdata,
    output int unsigned                      mismatches,
    output int unsigned                      results_awaited,
    output int unsigned                      top_mode_count,
    output int unsigned                      flagged_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import mth_pkg::*;

    localparam int VALUE_COUNT = DEF_VALUE_COUNT;
    localparam int BLOCK_SIZE  = DEF_BLOCK_SIZE;
    localparam int COUNT_MAX   = DEF_COUNT_MAX;
    localparam int NUM_BLOCKS  = (VALUE_COUNT + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int CNT_W       = $clog2(COUNT_MAX + 1);

    bit [CNT_W-1:0] value_tally [VALUE_COUNT];
    int unsigned    count_hist  [NUM_BLOCKS][COUNT_MAX + 1];
    bit [CNT_W-1:0] block_peak  [NUM_BLOCKS];

    result_t        predicted_results [$];

    initial
    begin
        mismatches      = 0;
        results_awaited = 0;
        top_mode_count  = 0;
        flagged_results = 0;
    end

    function automatic logic [STATUS_W-1:0] count_in(input logic [VALUE_W-1:0] v);
        int unsigned    blk;
        logic [CNT_W-1:0] c;
        if (int'(v) >= VALUE_COUNT)
            return STATUS_SATURATED;
        c = value_tally[v];
        if (int'(c) >= COUNT_MAX)
            return STATUS_SATURATED;
        blk = v / BLOCK_SIZE;
        if (c > 0)
            count_hist[blk][c] -= 1;
        c = c + 1'b1;
        value_tally[v] = c;
        count_hist[blk][c] += 1;
        if (c > block_peak[blk])
            block_peak[blk] = c;
        return STATUS_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] count_out(input logic [VALUE_W-1:0] v);
        int unsigned    blk;
        logic [CNT_W-1:0] c;
        if (int'(v) >= VALUE_COUNT)
            return STATUS_ABSENT;
        c = value_tally[v];
        if (c == 0)
            return STATUS_ABSENT;
        blk = v / BLOCK_SIZE;
        // last holder of the block maximum leaving lowers the maximum by one
        if (block_peak[blk] == c && count_hist[blk][c] == 1)
            block_peak[blk] = c - 1'b1;
        count_hist[blk][c] -= 1;
        c = c - 1'b1;
        value_tally[v] = c;
        if (c > 0)
            count_hist[blk][c] += 1;
        return STATUS_OK;
    endfunction

    function automatic result_t lookup_mode();
        result_t          r;
        logic [CNT_W-1:0] best;
        int               v;
        r    = '0;
        best = '0;
        for (int b = 0; b < NUM_BLOCKS; b++)
            if (block_peak[b] > best)
                best = block_peak[b];
        if (best == 0)
            return r;
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            if (block_peak[b] != best)
                continue;
            // only the first block reaching the maximum is walked
            for (int j = 0; j < BLOCK_SIZE; j++)
            begin
                v = b * BLOCK_SIZE + j;
                if (v >= VALUE_COUNT)
                    break;
                if (value_tally[v] == best)
                begin
                    r.mode_value = VALUE_W'(v);
                    r.mode_count = COUNT_OUT_W'(best);
                    return r;
                end
            end
            return r;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        result_t          want;
        result_t          got;
        logic [OP_W-1:0]  op;
        logic [VALUE_W-1:0] v;
        if (rst_n)
        begin
            // output side first: a result at this edge belongs to an earlier item
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[M_FIELDS_W-1:0]);
                if (predicted_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result status=%0d value=%0d count=%0d",
                                 $realtime, got.status, got.mode_value, got.mode_count);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.status != want.status || got.mode_value != want.mode_value
                        || got.mode_count != want.mode_count)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: result mismatch exp status=%0d value=%0d count=%0d",
                                     $realtime, want.status, want.mode_value,
                                     want.mode_count);
                            $display("%0t:                 got status=%0d value=%0d count=%0d",
                                     $realtime, got.status, got.mode_value, got.mode_count);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                op   = s_tdata[OP_W-1:0];
                v    = s_tdata[OP_W +: VALUE_W];
                want = '0;
                case (op)
                    OP_ADD:    want.status = count_in(v);
                    OP_REMOVE: want.status = count_out(v);
                    OP_QUERY:  want = lookup_mode();
                    default:   want = '0;
                endcase
                if (want.status != STATUS_OK)
                    flagged_results++;
                if (want.mode_count > top_mode_count)
                    top_mode_count = want.mode_count;
                predicted_results = {predicted_results, want};
            end
            results_awaited = predicted_results.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives add, remove, mode query and unused-operation items into the mode
// tracking histogram with random gaps and output stalls, and reports the
// verdict from the result checker that sits beside the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mth_pkg::*;

    localparam int CLK_PERIOD   = 12;
    // clearing pass plus ~1100 items at their slowest, several times over
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 40;
    // enough adds on one value to run past the count limit
    localparam int SAT_ADDS     = DEF_COUNT_MAX + 4;
    // a query walks every block maximum and one block
    localparam int DRAIN_CYCLES = 100;
    localparam int POOL_SIZE    = 12;

    // the one operation code the block does not define
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // operation[1:0], value[11:2], zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // status[1:0], mode_value[11:2], mode_count[21:12], zero

    int unsigned            mismatches;
    int unsigned            results_awaited;
    int unsigned            top_mode_count;
    int unsigned            flagged_results;

    // when set, both sides run back to back with no idle cycles
    bit                     no_idle;
    int unsigned            cycle_count;
    int unsigned            adds_sent;
    int unsigned            removes_sent;
    int unsigned            queries_sent;
    int unsigned            others_sent;

    mode_tracking_histogram DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mode_tracker_checker mode_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .results_awaited (results_awaited),
        .top_mode_count  (top_mode_count),
        .flagged_results (flagged_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case the block hangs
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one input transfer: random idle gap, then hold valid until accepted;
    // entered and left at a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            // idle cycles carry junk on tdata
            s_tdata  <= S_TDATA_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({v, op});
        do
            @(posedge clk);
        while (!s_tready);
        case (op)
            OP_ADD:    adds_sent++;
            OP_REMOVE: removes_sent++;
            OP_QUERY:  queries_sent++;
            default:   others_sent++;
        endcase
        @(negedge clk);
    endtask

    // receiver: stall a random number of cycles before taking each result
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] pool [POOL_SIZE];
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] sat_value;
        logic [OP_W-1:0]    op;
        int unsigned        roll;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        no_idle      = 1'b0;
        adds_sent    = 0;
        removes_sent = 0;
        queries_sent = 0;
        others_sent  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // the clearing pass after reset just shows up as a long wait on s_tready

        // ---- directed part ----
        send_item(OP_QUERY, 10'h3FF);    // empty set answers zeros
        send_item(OP_REMOVE, 10'd5);     // remove of an absent value
        send_item(OP_UNUSED, 10'h3FF);   // unused operation does nothing
        send_item(OP_ADD, 10'd0);
        send_item(OP_ADD, 10'h3FF);
        send_item(OP_QUERY, 10'd0);      // tie at count 1: smallest value wins
        send_item(OP_ADD, 10'h3FF);
        send_item(OP_QUERY, 10'h155);    // top value in the last block
        send_item(OP_ADD, 10'd40);
        send_item(OP_ADD, 10'd40);
        send_item(OP_QUERY, 10'h2AA);    // first block reaching the max is scanned
        send_item(OP_ADD, 10'd33);
        send_item(OP_ADD, 10'd33);
        send_item(OP_QUERY, 10'd0);      // two values at the max in one block
        send_item(OP_REMOVE, 10'd40);    // block max held by another value
        send_item(OP_REMOVE, 10'd33);    // last holder leaves, block max drops
        send_item(OP_QUERY, 10'd0);
        send_item(OP_REMOVE, 10'h3FF);
        send_item(OP_REMOVE, 10'h3FF);
        send_item(OP_REMOVE, 10'h3FF);   // now absent
        send_item(OP_ADD, 10'h2AA);
        send_item(OP_ADD, 10'h155);
        send_item(OP_REMOVE, 10'd0);
        send_item(OP_UNUSED, 10'd0);
        send_item(OP_QUERY, 10'd0);

        // hold off until the block has drained
        s_tvalid <= 1'b0;
        wait (results_awaited == 0);
        @(negedge clk);

        // ---- random part ----
        // a small pool keeps counts climbing and ties forming; it includes
        // both extremes and two pairs of values that share a block
        pool[0] = '0;
        pool[1] = '1;
        pool[2] = VALUE_W'($urandom_range(0, 31));
        pool[3] = pool[2] ^ 10'd1;
        pool[4] = VALUE_W'($urandom_range(0, 1023));
        pool[5] = {pool[4][9:5], 5'($urandom_range(0, 31))};
        for (int k = 6; k < POOL_SIZE; k++)
            pool[k] = VALUE_W'($urandom_range(0, 1023));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // the last quarter of each stretch of 20 items runs with no idling
            no_idle = (i % 20) >= 15;
            roll = $urandom_range(0, 99);
            if (roll < 45)
                op = OP_ADD;
            else if (roll < 75)
                op = OP_REMOVE;
            else if (roll < 95)
                op = OP_QUERY;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 9) < 7)
                v = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                v = VALUE_W'($urandom_range(0, 1023));
            send_item(op, v);
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        wait (results_awaited == 0);
        @(negedge clk);

        // ---- run one value up to the count limit and past it ----
        sat_value = VALUE_W'($urandom_range(0, 1023));
        for (int i = 0; i < SAT_ADDS; i++)
        begin
            // a middle stretch of the climb runs back to back on both sides
            no_idle = (i >= 256) && (i < 640);
            send_item(OP_ADD, sat_value);
            if (i % 128 == 127)
                send_item(OP_QUERY, VALUE_W'($urandom));
        end
        no_idle = 1'b0;
        send_item(OP_QUERY, sat_value);
        send_item(OP_REMOVE, sat_value);  // drops off the limit
        send_item(OP_QUERY, sat_value);
        send_item(OP_ADD, sat_value);
        send_item(OP_ADD, sat_value);     // saturates again
        send_item(OP_QUERY, sat_value);

        s_tvalid <= 1'b0;
        wait (results_awaited == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d add, %0d remove, %0d query and %0d unused-op items",
                 adds_sent, removes_sent, queries_sent, others_sent);
        $display("highest mode count reached %0d, %0d results flagged absent or saturated",
                 top_mode_count, flagged_results);
        if (mismatches == 0 && results_awaited == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mth_pkg.sv
hw/rtl/mth_ram.sv
hw/rtl/mth_out_reg.sv
hw/rtl/mth_engine.sv
hw/rtl/mode_tracking_histogram.sv
hw/rtl/mth_checker.sv
dv/mode_tracker_checker.sv
dv/testbench.sv
